@@ hdl/bqet_pkg.sv @@
// types, constants and codes shared by the bounded quota entry table
// no dependencies
`timescale 1ns / 1ps

package bqet_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int ID_BITS     = 32;
	localparam int QUOTA_BITS  = 48;
	localparam int STATE_BITS  = 3;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int LIVE_W      = 5;
	localparam int REQ_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [QUOTA_BITS-1:0] FALLBACK_QUOTA = QUOTA_BITS'(64'd1 << 30);
	localparam logic [LIVE_W-1:0]     LIMIT_MAX      = LIVE_W'(MAX_ENTRIES);

	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LIVE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_QUOTA = 1'b1;

	localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_DESTROY = 3'd1;
	localparam logic [REQ_W-1:0] REQ_SET     = 3'd2;
	localparam logic [REQ_W-1:0] REQ_ADJUST  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_LOOKUP  = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVER_QUOTA = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd3;

	typedef enum logic [1:0] {
		CELL_NOP,
		CELL_CREATE,
		CELL_STATE,
		CELL_USED
	} cell_op_t;

	// search wave passed from cell to cell
	typedef struct packed {
		logic                  hit;
		logic [IDX_W-1:0]      hit_idx;
		logic [STATE_BITS-1:0] hit_state;
		logic [QUOTA_BITS-1:0] hit_used;
		logic [QUOTA_BITS-1:0] hit_cap;
		logic                  have_min;
		logic [IDX_W-1:0]      min_idx;
		logic [ID_BITS-1:0]    min_id;
		logic                  have_free;
		logic [IDX_W-1:0]      free_idx;
	} wave_t;

	// update broadcast to all cells
	typedef struct packed {
		logic                  clr_en;
		logic [IDX_W-1:0]      clr_idx;
		cell_op_t              op;
		logic [IDX_W-1:0]      idx;
		logic [ID_BITS-1:0]    id;
		logic [STATE_BITS-1:0] state;
		logic [QUOTA_BITS-1:0] used;
		logic [QUOTA_BITS-1:0] cap;
	} cell_cmd_t;

endpackage

@@ hdl/bqet_if.sv @@
// request and response channel interfaces of the entry table
// depends on bqet_pkg
`timescale 1ns / 1ps

interface bqet_req_if;
	import bqet_pkg::*;
	logic                         valid;
	logic                         ready;
	logic [REQ_W-1:0]             req_type;
	logic [ID_BITS-1:0]           target_id;
	logic [STATE_BITS-1:0]        new_state;
	logic signed [QUOTA_BITS-1:0] quota_delta;

	modport source (output valid, req_type, target_id, new_state, quota_delta,
		input ready);
	modport sink (input valid, req_type, target_id, new_state, quota_delta,
		output ready);
endinterface

interface bqet_rsp_if;
	import bqet_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [ID_BITS-1:0]    result_id;
	logic [STATE_BITS-1:0] entry_state_out;
	logic [QUOTA_BITS-1:0] quota_used_out;
	logic [QUOTA_BITS-1:0] quota_cap_out;
	logic                  evicted;
	logic [ID_BITS-1:0]    evicted_id;
	logic [LIVE_W-1:0]     live_count;

	modport source (output valid, status, result_id, entry_state_out, quota_used_out,
		quota_cap_out, evicted, evicted_id, live_count, input ready);
	modport sink (input valid, status, result_id, entry_state_out, quota_used_out,
		quota_cap_out, evicted, evicted_id, live_count, output ready);
endinterface

@@ hdl/bounded_quota_entry_table_core.sv @@
// an accepted request sends a search wave along the chain of 16 slot cells, each of which
// registers the wave, then a decision step in EXEC loads the output register; one request
// in flight, and a new one is taken only once the last one has left EXEC
// the response register frees the request side while a response waits
// reset (arst_n low): table empty, next id 1, max_live 16, default quota 1 << 30
`timescale 1ns / 1ps

module bounded_quota_entry_table_core
	import bqet_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [QUOTA_BITS-1:0] cfg_data,
	bqet_req_if.sink              req,
	bqet_rsp_if.source            rsp
);

	typedef enum logic [1:0] {
		IDLE,
		SEARCH,
		EXEC
	} fsm_t;

	fsm_t                         state_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [LIVE_W-1:0]            max_live_q;
	logic [QUOTA_BITS-1:0]        dflt_quota_q;
	logic [ID_BITS-1:0]           next_id_q;
	logic [LIVE_W-1:0]            live_q;
	logic [REQ_W-1:0]             req_type_q;
	logic [ID_BITS-1:0]           tid_q;
	logic [STATE_BITS-1:0]        nst_q;
	logic [QUOTA_BITS-1:0]        dlt_q;

	logic                         rsp_valid_q;
	logic [STATUS_W-1:0]          status_q;
	logic [ID_BITS-1:0]           rid_q;
	logic [STATE_BITS-1:0]        est_q;
	logic [QUOTA_BITS-1:0]        used_q;
	logic [QUOTA_BITS-1:0]        cap_q;
	logic                         ev_q;
	logic [ID_BITS-1:0]           evid_q;

	wave_t                        wave [MAX_ENTRIES+1];
	cell_cmd_t                    cmd;
	wave_t                        res;
	logic                         exec_go;

	logic [STATUS_W-1:0]          status_d;
	logic [ID_BITS-1:0]           rid_d;
	logic [STATE_BITS-1:0]        est_d;
	logic [QUOTA_BITS-1:0]        used_d;
	logic [QUOTA_BITS-1:0]        cap_d;
	logic                         ev_d;
	logic [ID_BITS-1:0]           evid_d;
	logic [LIVE_W-1:0]            live_d;
	logic [ID_BITS-1:0]           next_id_d;
	logic [LIVE_W-1:0]            limit;
	logic [QUOTA_BITS-1:0]        new_cap;
	logic [QUOTA_BITS:0]          sum;
	logic [QUOTA_BITS-1:0]        mag;
	logic                         do_evict;
	logic                         have_slot;
	logic [IDX_W-1:0]             new_idx;
	logic [LIVE_W-1:0]            live_after_ev;

	assign wave[0] = '0;
	assign res     = wave[MAX_ENTRIES];

	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		bqet_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.slot_idx  (IDX_W'(g)),
			.target_id (tid_q),
			.wave_in   (wave[g]),
			.cmd       (cmd),
			.wave_out  (wave[g+1])
		);
	end

	assign req.ready = (state_q == IDLE);
	assign exec_go   = (state_q == EXEC) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		limit = (max_live_q == '0 || max_live_q > LIMIT_MAX) ? LIMIT_MAX : max_live_q;
		new_cap = (dflt_quota_q == '0) ? FALLBACK_QUOTA : dflt_quota_q;
		sum = {1'b0, res.hit_used} + {1'b0, dlt_q};
		mag = -dlt_q;
		do_evict = (live_q >= limit) && res.have_min;
		live_after_ev = (do_evict && live_q != '0) ? live_q - 1'b1 : live_q;
		if (do_evict) begin
			have_slot = 1'b1;
			new_idx = (res.have_free && res.free_idx < res.min_idx) ? res.free_idx
				: res.min_idx;
		end else begin
			have_slot = res.have_free;
			new_idx = res.free_idx;
		end

		status_d  = ST_OK;
		rid_d     = '0;
		est_d     = '0;
		used_d    = '0;
		cap_d     = '0;
		ev_d      = 1'b0;
		evid_d    = '0;
		live_d    = live_q;
		next_id_d = next_id_q;
		cmd       = '0;
		cmd.op    = CELL_NOP;

		if (req_type_q == REQ_CREATE) begin
			if (next_id_q == '0) begin
				status_d = ST_EXHAUSTED;
			end else begin
				if (do_evict) begin
					ev_d        = 1'b1;
					evid_d      = res.min_id;
					cmd.clr_en  = 1'b1;
					cmd.clr_idx = res.min_idx;
				end
				live_d = live_after_ev;
				if (have_slot) begin
					cmd.op    = CELL_CREATE;
					cmd.idx   = new_idx;
					cmd.id    = next_id_q;
					cmd.cap   = new_cap;
					next_id_d = next_id_q + 1'b1;
					live_d    = live_after_ev + 1'b1;
					rid_d     = next_id_q;
					cap_d     = new_cap;
				end
			end
		end else if (!res.hit) begin
			status_d = ST_NOT_FOUND;
		end else begin
			rid_d   = tid_q;
			est_d   = res.hit_state;
			used_d  = res.hit_used;
			cap_d   = res.hit_cap;
			cmd.idx = res.hit_idx;
			unique case (req_type_q)
				REQ_DESTROY: begin
					cmd.clr_en  = 1'b1;
					cmd.clr_idx = res.hit_idx;
					live_d      = (live_q != '0) ? live_q - 1'b1 : live_q;
				end
				REQ_SET: begin
					cmd.op    = CELL_STATE;
					cmd.state = nst_q;
					est_d     = nst_q;
				end
				REQ_ADJUST: begin
					if (!dlt_q[QUOTA_BITS-1]) begin
						if (sum > {1'b0, res.hit_cap}) begin
							status_d = ST_OVER_QUOTA;
							rid_d    = '0;
						end else begin
							cmd.op   = CELL_USED;
							cmd.used = sum[QUOTA_BITS-1:0];
							used_d   = sum[QUOTA_BITS-1:0];
						end
					end else begin
						cmd.op   = CELL_USED;
						cmd.used = (res.hit_used < mag) ? '0 : res.hit_used - mag;
						used_d   = cmd.used;
					end
				end
				default: begin
				end
			endcase
		end

		if (!exec_go) begin
			cmd.clr_en = 1'b0;
			cmd.op     = CELL_NOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			cnt_q        <= '0;
			max_live_q   <= LIMIT_MAX;
			dflt_quota_q <= FALLBACK_QUOTA;
			next_id_q    <= ID_BITS'(1);
			live_q       <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					CFG_MAX_LIVE:      max_live_q   <= cfg_data[LIVE_W-1:0];
					CFG_DEFAULT_QUOTA: dflt_quota_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (exec_go) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (req.valid) begin
						state_q <= SEARCH;
						cnt_q   <= '0;
					end
				end
				SEARCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IDX_W'(MAX_ENTRIES - 1)) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (exec_go) begin
						state_q     <= IDLE;
						next_id_q   <= next_id_d;
						live_q      <= live_d;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_q <= req.req_type;
			tid_q      <= req.target_id;
			nst_q      <= req.new_state;
			dlt_q      <= req.quota_delta;
		end
		if (exec_go) begin
			status_q <= status_d;
			rid_q    <= rid_d;
			est_q    <= est_d;
			used_q   <= used_d;
			cap_q    <= cap_d;
			ev_q     <= ev_d;
			evid_q   <= evid_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = status_q;
	assign rsp.result_id       = rid_q;
	assign rsp.entry_state_out = est_q;
	assign rsp.quota_used_out  = used_q;
	assign rsp.quota_cap_out   = cap_q;
	assign rsp.evicted         = ev_q;
	assign rsp.evicted_id      = evid_q;
	assign rsp.live_count      = live_q;

endmodule

@@ hdl/bqet_cell.sv @@
// one table slot: holds an entry and folds it into the search wave
// depends on bqet_pkg
`timescale 1ns / 1ps

module bqet_cell
	import bqet_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IDX_W-1:0]   slot_idx,
	input  logic [ID_BITS-1:0] target_id,
	input  wave_t              wave_in,
	input  cell_cmd_t          cmd,
	output wave_t              wave_out
);

	logic                  valid_q;
	logic [ID_BITS-1:0]    id_q;
	logic [STATE_BITS-1:0] state_q;
	logic [QUOTA_BITS-1:0] used_q;
	logic [QUOTA_BITS-1:0] cap_q;
	wave_t                 wave_q;
	wave_t                 wave_d;

	always_comb begin
		wave_d = wave_in;
		if (!wave_in.hit && valid_q && id_q == target_id) begin
			wave_d.hit       = 1'b1;
			wave_d.hit_idx   = slot_idx;
			wave_d.hit_state = state_q;
			wave_d.hit_used  = used_q;
			wave_d.hit_cap   = cap_q;
		end
		if (valid_q && (!wave_in.have_min || id_q < wave_in.min_id)) begin
			wave_d.have_min = 1'b1;
			wave_d.min_idx  = slot_idx;
			wave_d.min_id   = id_q;
		end
		if (!wave_in.have_free && !valid_q) begin
			wave_d.have_free = 1'b1;
			wave_d.free_idx  = slot_idx;
		end
	end

	always_ff @(posedge clk) begin
		wave_q <= wave_d;
	end

	assign wave_out = wave_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			if (cmd.op == CELL_CREATE && cmd.idx == slot_idx) begin
				valid_q <= 1'b1;
			end else if (cmd.clr_en && cmd.clr_idx == slot_idx) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.idx == slot_idx) begin
			unique case (cmd.op)
				CELL_CREATE: begin
					id_q    <= cmd.id;
					state_q <= cmd.state;
					used_q  <= cmd.used;
					cap_q   <= cmd.cap;
				end
				CELL_STATE: begin
					state_q <= cmd.state;
				end
				CELL_USED: begin
					used_q <= cmd.used;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ tb/tb_bounded_quota_entry_table_core.sv @@
// self-checking testbench for bounded_quota_entry_table_core: directed and random requests
// are checked against an in-bench table predictor. depends on bqet_pkg, bqet_if and the core
`timescale 1ns / 1ps

module tb_bounded_quota_entry_table_core;
	import bqet_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 24;

	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam logic signed [QUOTA_BITS-1:0] DELTA_MAX = {1'b0, {(QUOTA_BITS-1){1'b1}}};
	localparam logic signed [QUOTA_BITS-1:0] DELTA_MIN = {1'b1, {(QUOTA_BITS-1){1'b0}}};

	typedef struct packed {
		logic [REQ_W-1:0]             kind;
		logic [ID_BITS-1:0]           id;
		logic [STATE_BITS-1:0]        st;
		logic signed [QUOTA_BITS-1:0] delta;
	} table_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [ID_BITS-1:0]    result_id;
		logic [STATE_BITS-1:0] st;
		logic [QUOTA_BITS-1:0] used;
		logic [QUOTA_BITS-1:0] cap;
		logic                  evicted;
		logic [ID_BITS-1:0]    evicted_id;
		logic [LIVE_W-1:0]     live;
	} table_rsp_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [QUOTA_BITS-1:0] cfg_data;

	bqet_req_if req_ch ();
	bqet_rsp_if rsp_ch ();

	bounded_quota_entry_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// predicted table contents and settings
	logic                  tbl_valid [MAX_ENTRIES];
	logic [ID_BITS-1:0]    tbl_id    [MAX_ENTRIES];
	logic [STATE_BITS-1:0] tbl_state [MAX_ENTRIES];
	logic [QUOTA_BITS-1:0] tbl_used  [MAX_ENTRIES];
	logic [QUOTA_BITS-1:0] tbl_cap   [MAX_ENTRIES];
	logic [ID_BITS-1:0]    next_id;
	logic [LIVE_W-1:0]     live_n;
	logic [LIVE_W-1:0]     lim_cfg;
	logic [QUOTA_BITS-1:0] quota_cfg;

	table_rsp_t expected_responses[$];
	int mismatches;
	int src_idle_pct;
	int snk_idle_pct;
	int cycle_count;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("** bounded_quota_entry_table_core: FAILED **");
			$finish;
		end
	end

	function automatic int find_entry(logic [ID_BITS-1:0] id);
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (tbl_valid[i] && tbl_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic table_rsp_t predict_response(table_req_t r);
		table_rsp_t o;
		int hit;
		int oldest;
		int free_slot;
		logic [LIVE_W-1:0] lim;
		logic [QUOTA_BITS:0] sum;
		logic [QUOTA_BITS-1:0] mag;
		o = '0;
		lim = (lim_cfg == 0 || lim_cfg > LIMIT_MAX) ? LIMIT_MAX : lim_cfg;
		if (r.kind == REQ_CREATE) begin
			if (next_id == 0) begin
				o.status = ST_EXHAUSTED;
			end else begin
				if (live_n >= lim) begin
					oldest = -1;
					for (int i = 0; i < MAX_ENTRIES; i++)
						if (tbl_valid[i] && (oldest < 0 || tbl_id[i] < tbl_id[oldest]))
							oldest = i;
					if (oldest >= 0) begin
						tbl_valid[oldest] = 1'b0;
						o.evicted = 1'b1;
						o.evicted_id = tbl_id[oldest];
						if (live_n > 0)
							live_n--;
					end
				end
				free_slot = -1;
				for (int i = 0; i < MAX_ENTRIES; i++)
					if (!tbl_valid[i] && free_slot < 0)
						free_slot = i;
				if (free_slot >= 0) begin
					tbl_valid[free_slot] = 1'b1;
					tbl_id[free_slot] = next_id;
					tbl_state[free_slot] = '0;
					tbl_used[free_slot] = '0;
					tbl_cap[free_slot] = (quota_cfg == 0) ? FALLBACK_QUOTA : quota_cfg;
					next_id = next_id + 1'b1;
					live_n++;
					o.result_id = tbl_id[free_slot];
					o.cap = tbl_cap[free_slot];
				end
			end
		end else begin
			hit = find_entry(r.id);
			if (hit < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.result_id = r.id;
				case (r.kind)
					REQ_DESTROY: begin
						tbl_valid[hit] = 1'b0;
						if (live_n > 0)
							live_n--;
					end
					REQ_SET: tbl_state[hit] = r.st;
					REQ_ADJUST: begin
						if (!r.delta[QUOTA_BITS-1]) begin
							sum = {1'b0, tbl_used[hit]} + {1'b0, r.delta};
							if (sum > {1'b0, tbl_cap[hit]}) begin
								o.status = ST_OVER_QUOTA;
								o.result_id = '0;
							end else begin
								tbl_used[hit] = sum[QUOTA_BITS-1:0];
							end
						end else begin
							mag = -r.delta;
							tbl_used[hit] = (tbl_used[hit] < mag) ? '0 : tbl_used[hit] - mag;
						end
					end
					default: ;
				endcase
				o.st = tbl_state[hit];
				o.used = tbl_used[hit];
				o.cap = tbl_cap[hit];
			end
		end
		o.live = live_n;
		return o;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %0s: expected %0h actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin
		table_rsp_t exp_rsp;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response with nothing outstanding, result_id %0h",
						rsp_ch.result_id);
			end else begin
				exp_rsp = expected_responses.pop_front();
				check_field("status", 64'(exp_rsp.status), 64'(rsp_ch.status));
				check_field("result_id", 64'(exp_rsp.result_id), 64'(rsp_ch.result_id));
				check_field("entry_state_out", 64'(exp_rsp.st),
					64'(rsp_ch.entry_state_out));
				check_field("quota_used_out", 64'(exp_rsp.used),
					64'(rsp_ch.quota_used_out));
				check_field("quota_cap_out", 64'(exp_rsp.cap), 64'(rsp_ch.quota_cap_out));
				check_field("evicted", 64'(exp_rsp.evicted), 64'(rsp_ch.evicted));
				check_field("evicted_id", 64'(exp_rsp.evicted_id), 64'(rsp_ch.evicted_id));
				check_field("live_count", 64'(exp_rsp.live), 64'(rsp_ch.live_count));
			end
		end
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	function automatic table_req_t make_req(logic [REQ_W-1:0] kind,
		logic [ID_BITS-1:0] id, logic [STATE_BITS-1:0] st = '0,
		logic signed [QUOTA_BITS-1:0] delta = '0);
		table_req_t r;
		r.kind = kind;
		r.id = id;
		r.st = st;
		r.delta = delta;
		return r;
	endfunction

	task automatic send_request(table_req_t item);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= item.kind;
		req_ch.target_id <= item.id;
		req_ch.new_state <= item.st;
		req_ch.quota_delta <= item.delta;
		do @(posedge clk); while (!req_ch.ready);
		expected_responses.push_back(predict_response(item));
	endtask

	task automatic drain_responses();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (expected_responses.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [QUOTA_BITS-1:0] value);
		drain_responses();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_LIVE)
			lim_cfg = value[LIVE_W-1:0];
		else
			quota_cfg = value;
	endtask

	function automatic logic [ID_BITS-1:0] pick_target();
		logic [ID_BITS-1:0] alive[$];
		int roll;
		roll = $urandom_range(99);
		for (int i = 0; i < MAX_ENTRIES; i++)
			if (tbl_valid[i])
				alive.push_back(tbl_id[i]);
		if (roll < 65 && alive.size() > 0)
			return alive[$urandom_range(alive.size() - 1)];
		if (roll < 80)
			return next_id - ID_BITS'($urandom_range(1, 20));
		if (roll < 85)
			return '0;
		if (roll < 90)
			return next_id;
		return $urandom;
	endfunction

	function automatic logic signed [QUOTA_BITS-1:0] pick_delta(logic [ID_BITS-1:0] id);
		int s;
		logic [QUOTA_BITS-1:0] room;
		logic [QUOTA_BITS-1:0] d;
		s = find_entry(id);
		if (s < 0)
			return QUOTA_BITS'({$urandom, $urandom});
		room = tbl_cap[s] - tbl_used[s];
		case ($urandom_range(0, 6))
			0: d = QUOTA_BITS'($urandom_range(0, 40));
			1: d = -QUOTA_BITS'($urandom_range(1, 40));
			2: d = room;
			3: d = room + 1'b1;
			4: d = QUOTA_BITS'({$urandom, $urandom});
			5: d = DELTA_MAX;
			default: d = DELTA_MIN;
		endcase
		return d;
	endfunction

	function automatic table_req_t random_request();
		table_req_t r;
		int roll;
		roll = $urandom_range(99);
		r.id = pick_target();
		r.st = STATE_BITS'($urandom_range(0, 7));
		r.delta = QUOTA_BITS'({$urandom, $urandom});
		if (roll < 25) begin
			r.kind = REQ_CREATE;
			r.id = $urandom;
		end else if (roll < 35) begin
			r.kind = REQ_DESTROY;
		end else if (roll < 50) begin
			r.kind = REQ_SET;
		end else if (roll < 80) begin
			r.kind = REQ_ADJUST;
			r.delta = pick_delta(r.id);
		end else if (roll < 95) begin
			r.kind = REQ_LOOKUP;
		end else begin
			r.kind = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return r;
	endfunction

	task automatic test_missing_ids();
		send_request(make_req(REQ_LOOKUP, '0));
		send_request(make_req(REQ_DESTROY, 32'd5));
		send_request(make_req(REQ_ADJUST, '1, '0, 48'sd1));
		send_request(make_req(REQ_SET, 32'h8000_0000, 3'd7));
	endtask

	task automatic test_quota_bounds();
		logic [ID_BITS-1:0] id;
		send_request(make_req(REQ_CREATE, '0));
		write_config(CFG_DEFAULT_QUOTA, '0);
		send_request(make_req(REQ_CREATE, '0));
		write_config(CFG_DEFAULT_QUOTA, 48'd100);
		id = next_id;
		send_request(make_req(REQ_CREATE, '1));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd100));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd1));
		send_request(make_req(REQ_ADJUST, id, '0, -48'sd30));
		send_request(make_req(REQ_ADJUST, id, '0, DELTA_MIN));
		send_request(make_req(REQ_ADJUST, id, '0, DELTA_MAX));
		send_request(make_req(REQ_SET, id, 3'd7));
		send_request(make_req(REQ_SPARE_LO, id));
		send_request(make_req(REQ_SPARE_HI, id));
		send_request(make_req(REQ_DESTROY, id));
		send_request(make_req(REQ_LOOKUP, id));
		write_config(CFG_DEFAULT_QUOTA, 48'd1);
		id = next_id;
		send_request(make_req(REQ_CREATE, '0));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd1));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd1));
	endtask

	task automatic test_live_limit();
		// live count sits above the lowered limit: each create evicts only one
		write_config(CFG_MAX_LIVE, 48'd2);
		send_request(make_req(REQ_CREATE, '0));
		write_config(CFG_MAX_LIVE, 48'd1);
		send_request(make_req(REQ_CREATE, '0));
		write_config(CFG_MAX_LIVE, 48'd0);
		send_request(make_req(REQ_CREATE, '0));
		write_config(CFG_MAX_LIVE, 48'd31);
		send_request(make_req(REQ_CREATE, '0));
	endtask

	task automatic test_wide_quota();
		logic [ID_BITS-1:0] id;
		write_config(CFG_DEFAULT_QUOTA, '1);
		id = next_id;
		send_request(make_req(REQ_CREATE, '0));
		send_request(make_req(REQ_ADJUST, id, '0, DELTA_MAX));
		send_request(make_req(REQ_ADJUST, id, '0, DELTA_MAX));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd2));
		send_request(make_req(REQ_ADJUST, id, '0, 48'sd1));
	endtask

	task automatic test_random_traffic(int count, logic [QUOTA_BITS-1:0] limit,
		logic [QUOTA_BITS-1:0] quota);
		write_config(CFG_MAX_LIVE, limit);
		write_config(CFG_DEFAULT_QUOTA, quota);
		repeat (count)
			send_request(random_request());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = '0;
		req_ch.target_id = '0;
		req_ch.new_state = '0;
		req_ch.quota_delta = '0;
		mismatches = 0;
		cycle_count = 0;
		src_idle_pct = 11;
		snk_idle_pct = 64;
		for (int i = 0; i < MAX_ENTRIES; i++)
			tbl_valid[i] = 1'b0;
		next_id = 1;
		live_n = '0;
		lim_cfg = LIMIT_MAX;
		quota_cfg = FALLBACK_QUOTA;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_missing_ids();
		test_quota_bounds();
		test_live_limit();
		test_wide_quota();
		test_random_traffic(150, 48'd4, 48'd500);
		drain_responses();
		src_idle_pct = 64;
		snk_idle_pct = 11;
		test_random_traffic(150, 48'd16, 48'd2000);
		drain_responses();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random_traffic(150, 48'd9, '1);
		drain_responses();

		if (mismatches == 0)
			$display("** bounded_quota_entry_table_core: PASSED **");
		else
			$display("** bounded_quota_entry_table_core: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/bqet_pkg.sv
hdl/bqet_if.sv
hdl/bqet_cell.sv
hdl/bounded_quota_entry_table_core.sv
tb/tb_bounded_quota_entry_table_core.sv
